### rtl/obw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package obw_pkg;

    // Width of the per-phase tick counter and of every timing register.
    localparam int TICK_BITS = 10;
    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd6;

    // Values after reset, in ticks.
    localparam logic [TICK_BITS-1:0] RST_RESET_LOW     = 10'd480;
    localparam logic [TICK_BITS-1:0] RST_PRESENCE_WAIT = 10'd60;
    localparam logic [TICK_BITS-1:0] RST_RESET_TAIL    = 10'd420;
    localparam logic [TICK_BITS-1:0] RST_SLOT_START    = 10'd1;
    localparam logic [TICK_BITS-1:0] RST_SAMPLE_WAIT   = 10'd1;
    localparam logic [TICK_BITS-1:0] RST_SLOT_HOLD     = 10'd60;
    localparam logic [TICK_BITS-1:0] RST_RECOVERY      = 10'd1;

    // Command codes.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESET   = 3'd1;
    localparam logic [2:0] OP_WR_BYTE = 3'd2;
    localparam logic [2:0] OP_RD_BYTE = 3'd3;
    localparam logic [2:0] OP_WR_BIT  = 3'd4;
    localparam logic [2:0] OP_RD_BIT  = 3'd5;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_SLOT_LOW = 4'd4;
    localparam logic [3:0] PH_W_HOLD   = 4'd5;
    localparam logic [3:0] PH_W_REC    = 4'd6;
    localparam logic [3:0] PH_R_WAIT   = 4'd7;
    localparam logic [3:0] PH_R_END    = 4'd8;

    typedef struct packed {
        logic [TICK_BITS-1:0] reset_low;
        logic [TICK_BITS-1:0] presence_wait;
        logic [TICK_BITS-1:0] reset_tail;
        logic [TICK_BITS-1:0] slot_start;
        logic [TICK_BITS-1:0] sample_wait;
        logic [TICK_BITS-1:0] slot_hold;
        logic [TICK_BITS-1:0] recovery;
    } t_cfg;

    typedef struct packed {
        logic       no_device;
        logic [7:0] rd_data;
        logic       done_res;
        logic       busy_res;
        logic       line_release;
    } t_result;

endpackage

`default_nettype wire

### rtl/obw_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

// Timing register file, written through a plain write port.
module obw_cfg
    import obw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_BITS-1:0] i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RST_RESET_LOW;
            r_cfg.presence_wait <= RST_PRESENCE_WAIT;
            r_cfg.reset_tail    <= RST_RESET_TAIL;
            r_cfg.slot_start    <= RST_SLOT_START;
            r_cfg.sample_wait   <= RST_SAMPLE_WAIT;
            r_cfg.slot_hold     <= RST_SLOT_HOLD;
            r_cfg.recovery      <= RST_RECOVERY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_wdata;
                REG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_wdata;
                REG_RESET_TAIL:    r_cfg.reset_tail    <= i_cfg_wdata;
                REG_SLOT_START:    r_cfg.slot_start    <= i_cfg_wdata;
                REG_SAMPLE_WAIT:   r_cfg.sample_wait   <= i_cfg_wdata;
                REG_SLOT_HOLD:     r_cfg.slot_hold     <= i_cfg_wdata;
                REG_RECOVERY:      r_cfg.recovery      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/obw_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Bus sequencer: holds the operation state and advances it by one tick per beat.
module obw_seq
    import obw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [2:0] i_opcode,
    input  wire logic [7:0] i_wr_data,
    input  wire logic       i_line_in,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    logic [3:0]           r_phase;
    logic [2:0]           r_op_kind;
    logic [TICK_BITS-1:0] r_tick_count;
    logic [2:0]           r_bit_index;
    logic [7:0]           r_shift_reg;
    logic                 r_presence;

    logic [3:0]           n_phase;
    logic [2:0]           n_op_kind;
    logic [TICK_BITS-1:0] n_tick_count;
    logic [2:0]           n_bit_index;
    logic [7:0]           n_shift_reg;
    logic                 n_presence;

    logic                 start;
    logic [3:0]           cur_phase;
    logic [TICK_BITS-1:0] cur_tick;
    logic [TICK_BITS-1:0] dur;
    logic [TICK_BITS-1:0] dur_eff;
    logic                 fin;
    logic                 done;
    logic                 release_lvl;
    logic                 byte_op;
    logic                 wr_op;

    // A command only starts from idle; that beat is already its first tick.
    assign start = (r_phase == PH_IDLE) && (i_opcode >= OP_RESET) && (i_opcode <= OP_RD_BIT);
    assign cur_phase = start ? ((i_opcode == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW) : r_phase;
    assign cur_tick  = start ? '0 : r_tick_count;

    always_comb begin
        unique case (cur_phase)
            PH_RST_LOW:  dur = i_cfg.reset_low;
            PH_RST_WAIT: dur = i_cfg.presence_wait;
            PH_RST_TAIL: dur = i_cfg.reset_tail;
            PH_SLOT_LOW: dur = i_cfg.slot_start;
            PH_W_HOLD:   dur = i_cfg.slot_hold;
            PH_W_REC:    dur = i_cfg.recovery;
            PH_R_WAIT:   dur = i_cfg.sample_wait;
            PH_R_END:    dur = i_cfg.slot_hold;
            default:     dur = TICK_BITS'(1);
        endcase
    end

    // A zero duration counts as one tick.
    assign dur_eff = (dur == '0) ? TICK_BITS'(1) : dur;
    assign fin = (({1'b0, cur_tick} + (TICK_BITS+1)'(1)) >= {1'b0, dur_eff});

    always_comb begin
        n_op_kind    = start ? i_opcode : r_op_kind;
        n_bit_index  = start ? 3'd0 : r_bit_index;
        n_presence   = r_presence;
        n_phase      = cur_phase;
        n_tick_count = fin ? '0 : cur_tick + TICK_BITS'(1);
        done         = 1'b0;
        release_lvl  = 1'b1;
        if (start) begin
            if (i_opcode == OP_WR_BYTE) begin
                n_shift_reg = i_wr_data;
            end else if (i_opcode == OP_WR_BIT) begin
                n_shift_reg = {7'd0, i_wr_data[0]};
            end else begin
                n_shift_reg = 8'd0;
            end
        end else begin
            n_shift_reg = r_shift_reg;
        end
        byte_op = (n_op_kind == OP_WR_BYTE) || (n_op_kind == OP_RD_BYTE);
        wr_op   = (n_op_kind == OP_WR_BYTE) || (n_op_kind == OP_WR_BIT);

        unique case (cur_phase)
            PH_IDLE: begin
                n_tick_count = cur_tick;
            end
            PH_RST_LOW: begin
                release_lvl = 1'b0;
                if (fin) n_phase = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                if (fin) begin
                    n_presence = i_line_in;
                    n_phase    = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL: begin
                if (fin) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_SLOT_LOW: begin
                release_lvl = 1'b0;
                if (fin) n_phase = wr_op ? PH_W_HOLD : PH_R_WAIT;
            end
            PH_W_HOLD: begin
                release_lvl = n_shift_reg[0];
                if (fin) n_phase = PH_W_REC;
            end
            PH_R_WAIT: begin
                if (fin) begin
                    if (n_op_kind == OP_RD_BYTE) begin
                        n_shift_reg = {i_line_in, n_shift_reg[7:1]};
                    end else begin
                        n_shift_reg = {7'd0, i_line_in};
                    end
                    n_phase = PH_R_END;
                end
            end
            PH_W_REC, PH_R_END: begin
                // End of a slot: move on to the next bit of a byte, or finish.
                if (fin) begin
                    if (byte_op && (n_bit_index != 3'd7)) begin
                        n_bit_index = n_bit_index + 3'd1;
                        if (n_op_kind == OP_WR_BYTE) n_shift_reg = {1'b0, n_shift_reg[7:1]};
                        n_phase = PH_SLOT_LOW;
                    end else begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            default: begin
                n_phase      = PH_IDLE;
                n_tick_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_op_kind    <= OP_TICK;
            r_tick_count <= '0;
            r_bit_index  <= 3'd0;
            r_shift_reg  <= 8'd0;
            r_presence   <= 1'b1;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_op_kind    <= n_op_kind;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_reg  <= n_shift_reg;
            r_presence   <= n_presence;
        end
    end

    assign o_result.line_release = release_lvl;
    assign o_result.busy_res     = (n_phase != PH_IDLE);
    assign o_result.done_res     = done;
    assign o_result.rd_data      =
        (done && ((n_op_kind == OP_RD_BYTE) || (n_op_kind == OP_RD_BIT))) ? n_shift_reg : 8'd0;
    assign o_result.no_device    = n_presence;

    // The tick counter is always cleared while no operation runs.
    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick_count == '0))
        else $error("tick counter not cleared in idle");

    // Finishing an operation leaves the master idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_result.done_res) |=> (r_phase == PH_IDLE))
        else $error("done reported while operation continues");

    // The bus is only pulled low inside an operation.
    a_low_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.line_release |-> o_result.busy_res)
        else $error("bus driven low while idle");

    // Read data is shown only on the finishing tick.
    a_rd_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.rd_data != 8'd0) |-> o_result.done_res)
        else $error("read data outside done");

endmodule

`default_nettype wire

### rtl/onewire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-wire bus master driven by a stream of tick beats.
// Every beat on the slave stream is one bus tick. Its tdata carries a command
// (tick, reset/presence, write byte, read byte, write bit, read bit), the byte
// to send and the bus level sampled for this tick. A command beat arriving while
// idle starts the operation and is already its first tick; while busy it is a
// plain tick. Each input beat yields exactly one result beat on the master
// stream: the line level to drive for this tick, busy, a done pulse, the read
// byte (valid with done) and the last presence sample.
// The result beat comes in the cycle after its input beat, and one beat per cycle
// is taken: the sequencer advances its phase and tick counter in a single short
// pass and the result lands in the output register. The input is still taken
// while a result waits, as long as the receiver takes that result in the same
// cycle; when the receiver stalls, tready drops and the held result stays put.
// The user writes timing registers through the plain write port only while idle;
// this is not enforced. Synchronous active-low reset loads default timings, puts
// the sequencer in idle with no device seen, and empties the output register.
module onewire_bus_master
    import obw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [2:0] opcode, [10:3] wr_data, [11] line_in, [15:12] zero
    input  wire logic [15:0]          i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [0] line_release, [1] busy_res, [2] done_res, [10:3] rd_data,
    // [11] no_device, [15:12] zero
    output logic [15:0]               o_m_axis_tdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TICK_BITS-1:0] i_cfg_wdata
);

    t_cfg        cfg;
    t_result     result;
    logic        accept;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    obw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    obw_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_opcode  (i_s_axis_tdata[2:0]),
        .i_wr_data (i_s_axis_tdata[10:3]),
        .i_line_in (i_s_axis_tdata[11]),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Output register: loaded on every accepted beat, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {4'd0, result.no_device, result.rd_data, result.done_res,
                           result.busy_res, result.line_release};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
